// ===== src/kmdr_pkg.sv =====
// Shared constants and types of the key matrix debounce and report unit.
package kmdr_pkg;

  localparam int NUM_ROWS_DEF = 5;
  localparam int NUM_COLS_DEF = 5;
  localparam int REPORT_SLOTS_DEF = 6;
  localparam int SHOWN_SLOTS = 6;
  localparam int CODE_W = 8;
  localparam int CNT_W = 8;
  localparam int SCAN_BITS = 5;

  localparam logic [CODE_W-1:0] FIRST_CODE = 8'h04;
  localparam logic [CNT_W-1:0] THR_RESET = 8'd5;
  localparam logic [CNT_W-1:0] THR_TOP = 8'hff;
  localparam logic [CNT_W-1:0] THR_MAX = 8'd254;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_MAP = 1'b1;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

  typedef struct packed {
    logic en;
    logic [CODE_W-1:0] find;
    logic [CODE_W-1:0] put;
  } slot_op_t;

  typedef struct packed {
    logic done;
    logic changed;
  } done_t;

endpackage

// ===== src/kmdr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module kmdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kmdr_slots.sv =====
// Report slot registers with a first-match search for adding and removing codes.
module kmdr_slots #(
  parameter int REPORT_SLOTS = kmdr_pkg::REPORT_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kmdr_pkg::slot_op_t   op,
  output logic [8*kmdr_pkg::SHOWN_SLOTS-1:0] report
);

  logic [kmdr_pkg::CODE_W-1:0] slots [REPORT_SLOTS];
  logic [REPORT_SLOTS-1:0] hit;
  logic [REPORT_SLOTS-1:0] first;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      hit[i] = (slots[i] == op.find);
      first[i] = hit[i] && !seen;
      seen = seen || hit[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (op.en) begin
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        if (first[i]) begin
          slots[i] <= op.put;
        end
      end
    end
  end

  for (genvar g = 0; g < kmdr_pkg::SHOWN_SLOTS; g++) begin : g_pack
    if (g < REPORT_SLOTS) begin : g_used
      assign report[8*g +: 8] = slots[g];
    end else begin : g_empty
      assign report[8*g +: 8] = 8'd0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (op.en && !(|hit)) |=> $stable(report))
    else $error("Slots changed although no slot matched the search.");

endmodule

// ===== src/kmdr_ctrl.sv =====
// Scan sequencer: reads, updates and writes back per-key counts and keymap entries.
module kmdr_ctrl #(
  parameter int NUM_ROWS = kmdr_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = kmdr_pkg::NUM_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kmdr_pkg::CNT_W-1:0]    threshold,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [2:0]                    row_index,
  input  logic [kmdr_pkg::SCAN_BITS-1:0] column_bits,
  input  logic [4:0]                    map_index,
  input  logic [kmdr_pkg::CODE_W-1:0]   map_code,
  input  logic                          out_free,
  output kmdr_pkg::done_t               done,
  output kmdr_pkg::slot_op_t            slot_op
);

  localparam int KEY_COUNT = NUM_ROWS * NUM_COLS;
  localparam int KEY_W = KEY_COUNT > 1 ? $clog2(KEY_COUNT) : 1;
  localparam int COL_W = $clog2(NUM_COLS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic issuing;
  logic [COL_W-1:0] issue_cnt;
  logic [KEY_W-1:0] rd_addr;
  logic [kmdr_pkg::SCAN_BITS-1:0] col_bits;
  logic s1_valid;
  logic s1_down;
  logic [KEY_W-1:0] s1_addr;
  logic s1_cnt_valid;
  logic s1_code_valid;
  logic changed_acc;
  logic [KEY_COUNT-1:0] cnt_valid;
  logic [KEY_COUNT-1:0] code_valid;

  logic in_accept;
  logic row_ok;
  logic map_ok;
  logic code_we;
  logic [kmdr_pkg::CNT_W-1:0] thr;
  logic [kmdr_pkg::CNT_W-1:0] cnt_rdata;
  logic [kmdr_pkg::CODE_W-1:0] code_rdata;
  logic [kmdr_pkg::CNT_W-1:0] cnt;
  logic [kmdr_pkg::CODE_W-1:0] code;
  logic [kmdr_pkg::CNT_W-1:0] cnt_next;
  logic press;
  logic release_key;

  assign in_stall = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign row_ok = int'(row_index) < NUM_ROWS;
  assign map_ok = int'(map_index) < KEY_COUNT;
  assign code_we = in_accept && (command == kmdr_pkg::CMD_MAP) && map_ok;
  assign thr = (threshold == kmdr_pkg::THR_TOP) ? kmdr_pkg::THR_MAX : threshold;

  kmdr_ram #(.WIDTH(kmdr_pkg::CNT_W), .DEPTH(KEY_COUNT)) u_cnt_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (cnt_next),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  kmdr_ram #(.WIDTH(kmdr_pkg::CODE_W), .DEPTH(KEY_COUNT)) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (KEY_W'(map_index)),
    .wdata (map_code),
    .raddr (rd_addr),
    .rdata (code_rdata)
  );

  always_comb begin
    cnt = s1_cnt_valid ? cnt_rdata : '0;
    code = s1_code_valid ? code_rdata
                         : kmdr_pkg::CODE_W'(int'(kmdr_pkg::FIRST_CODE) + int'(s1_addr));
    cnt_next = cnt;
    press = 1'b0;
    release_key = 1'b0;
    if (s1_down) begin
      if (cnt < thr) begin
        cnt_next = cnt + 1'b1;
      end else if (cnt == thr) begin
        press = 1'b1;
        cnt_next = cnt + 1'b1;
      end
    end else if (cnt > thr) begin
      release_key = 1'b1;
      cnt_next = '0;
    end
    slot_op.en = s1_valid && (press || release_key);
    slot_op.find = press ? '0 : code;
    slot_op.put = press ? code : '0;
  end

  assign done.done = (state == ST_DONE);
  assign done.changed = changed_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issuing <= 1'b0;
      s1_valid <= 1'b0;
      changed_acc <= 1'b0;
      cnt_valid <= '0;
      code_valid <= '0;
    end else begin
      if (code_we) begin
        code_valid[KEY_W'(map_index)] <= 1'b1;
      end
      if (s1_valid) begin
        cnt_valid[s1_addr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            changed_acc <= 1'b0;
            if (command == kmdr_pkg::CMD_SCAN && row_ok) begin
              state <= ST_SCAN;
              issuing <= 1'b1;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          s1_valid <= issuing;
          if (issuing && issue_cnt == COL_W'(NUM_COLS - 1)) begin
            issuing <= 1'b0;
          end
          if (slot_op.en) begin
            changed_acc <= 1'b1;
          end
          if (!issuing && !s1_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      issue_cnt <= '0;
      rd_addr <= KEY_W'(int'(row_index) * NUM_COLS);
      col_bits <= column_bits;
    end else if (issuing) begin
      issue_cnt <= issue_cnt + 1'b1;
      rd_addr <= rd_addr + 1'b1;
      col_bits <= col_bits >> 1;
    end
    s1_down <= col_bits[0];
    s1_addr <= rd_addr;
    s1_cnt_valid <= cnt_valid[rd_addr];
    s1_code_valid <= code_valid[rd_addr];
  end

  assert property (@(posedge clk) disable iff (rst)
    (in_accept && (command == kmdr_pkg::CMD_MAP || !row_ok)) |=> (state == ST_DONE))
    else $error("A transfer without a row scan did not complete directly.");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (state == ST_SCAN))
    else $error("A column was processed outside a row scan.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!issuing && !s1_valid))
    else $error("Scan pipeline still busy while idle.");

endmodule

// ===== src/key_matrix_debounce_report_unit.sv =====
// Top level of the key matrix debounce and report unit.
// The input channel takes one command per transfer: a row scan (row index and
// column bits) or a keymap write (entry index and code). The register port
// holds the debounce threshold at byte address 0; the user must write it only
// while the unit is idle (the unit itself does not enforce this). Every input
// transfer yields exactly one output transfer carrying the changed flag and
// the six report slot bytes after the command. A row scan walks the columns
// of the row through the count and keymap RAMs, one column per cycle, with
// registered reads; a keymap write or a scan of a row outside the matrix goes
// straight to the done state. One command is handled at a time, and the next
// is accepted in the cycle after the result is loaded. The result sits in an
// output register, so it can wait on a stalled output while the next command
// is accepted and processed; that command then holds its result until the
// register frees. Reset clears all counts and slots, restores the default
// keymap and sets the threshold to 5.
module key_matrix_debounce_report_unit #(
  parameter int NUM_ROWS = kmdr_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLS = kmdr_pkg::NUM_COLS_DEF,
  parameter int REPORT_SLOTS = kmdr_pkg::REPORT_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [2:0]                          row_index,
  input  logic [kmdr_pkg::SCAN_BITS-1:0]      column_bits,
  input  logic [4:0]                          map_index,
  input  logic [kmdr_pkg::CODE_W-1:0]         map_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                changed,
  output logic [8*kmdr_pkg::SHOWN_SLOTS-1:0]  report_slots
);

  logic [kmdr_pkg::CNT_W-1:0] threshold;
  logic out_free;
  kmdr_pkg::done_t done;
  kmdr_pkg::slot_op_t slot_op;
  logic [8*kmdr_pkg::SHOWN_SLOTS-1:0] report;

  assign pready = 1'b1;
  assign prdata = (paddr == kmdr_pkg::ADDR_THRESHOLD) ? 32'(threshold) : 32'd0;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= kmdr_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == kmdr_pkg::ADDR_THRESHOLD) begin
      threshold <= pwdata[kmdr_pkg::CNT_W-1:0];
    end
  end

  kmdr_ctrl #(.NUM_ROWS(NUM_ROWS), .NUM_COLS(NUM_COLS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .threshold   (threshold),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .row_index   (row_index),
    .column_bits (column_bits),
    .map_index   (map_index),
    .map_code    (map_code),
    .out_free    (out_free),
    .done        (done),
    .slot_op     (slot_op)
  );

  kmdr_slots #(.REPORT_SLOTS(REPORT_SLOTS)) u_slots (
    .clk    (clk),
    .rst    (rst),
    .op     (slot_op),
    .report (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done.done && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.done && out_free) begin
      changed <= done.changed;
      report_slots <= report;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (done.done && !out_valid) |=> (out_valid && report_slots == $past(report)))
    else $error("A finished command did not load its result transfer.");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the key matrix debounce and report unit.
module testbench;

  localparam int ROWS = kmdr_pkg::NUM_ROWS_DEF;
  localparam int COLS = kmdr_pkg::NUM_COLS_DEF;
  localparam int KEYS = ROWS * COLS;
  localparam int SLOTS = kmdr_pkg::REPORT_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic changed;
    logic [8*kmdr_pkg::SHOWN_SLOTS-1:0] slots;
  } report_t;

  typedef struct packed {
    logic cmd;
    logic [2:0] row;
    logic [kmdr_pkg::SCAN_BITS-1:0] bits;
    logic [4:0] idx;
    logic [kmdr_pkg::CODE_W-1:0] code;
  } scan_item_t;

  typedef struct packed {
    scan_item_t item;
    logic typed;
    report_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = kmdr_pkg::CMD_SCAN;
  logic [2:0] row_index = '0;
  logic [kmdr_pkg::SCAN_BITS-1:0] column_bits = '0;
  logic [4:0] map_index = '0;
  logic [kmdr_pkg::CODE_W-1:0] map_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic changed;
  logic [8*kmdr_pkg::SHOWN_SLOTS-1:0] report_slots;

  logic [kmdr_pkg::CNT_W-1:0] threshold;
  logic [kmdr_pkg::CNT_W-1:0] key_count [KEYS];
  logic [kmdr_pkg::CODE_W-1:0] key_code [KEYS];
  logic [kmdr_pkg::CODE_W-1:0] slot_code [SLOTS];
  logic [kmdr_pkg::SCAN_BITS-1:0] held [ROWS];

  report_t report_queue [$];
  int errors = 0;
  int sent_count = 0;
  int send_idle = 25;
  int recv_idle = 86;
  int cycle_count = 0;

  directed_row_t directed [24] = '{
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b00000, 5'd0, 8'h00}, 1'b1, '{1'b0, 48'h0}},
    '{'{kmdr_pkg::CMD_SCAN, 3'd7, 5'b11111, 5'd31, 8'hff}, 1'b1, '{1'b0, 48'h0}},
    '{'{kmdr_pkg::CMD_SCAN, 3'd5, 5'b11111, 5'd0, 8'h00}, 1'b1, '{1'b0, 48'h0}},
    '{'{kmdr_pkg::CMD_MAP, 3'd0, 5'b00000, 5'd31, 8'hff}, 1'b1, '{1'b0, 48'h0}},
    '{'{kmdr_pkg::CMD_MAP, 3'd7, 5'b11111, 5'd25, 8'h11}, 1'b1, '{1'b0, 48'h0}},
    '{'{kmdr_pkg::CMD_MAP, 3'd0, 5'b00000, 5'd24, 8'h00}, 1'b1, '{1'b0, 48'h0}},
    '{'{kmdr_pkg::CMD_MAP, 3'd0, 5'b00000, 5'd0, 8'hff}, 1'b1, '{1'b0, 48'h0}},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd4, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd4, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd4, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd4, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd4, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd4, 5'b11111, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b11110, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_MAP, 3'd0, 5'b00000, 5'd1, 8'h33}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd0, 5'b00000, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd4, 5'b00000, 5'd0, 8'h00}, 1'b0, '0},
    '{'{kmdr_pkg::CMD_SCAN, 3'd2, 5'b11111, 5'd0, 8'h00}, 1'b0, '0}
  };

  key_matrix_debounce_report_unit u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .row_index(row_index), .column_bits(column_bits),
    .map_index(map_index), .map_code(map_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .changed(changed), .report_slots(report_slots)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic report_t predict_report(input scan_item_t it);
    report_t r;
    logic [kmdr_pkg::CNT_W-1:0] lim;
    logic [kmdr_pkg::CODE_W-1:0] code;
    int k;
    bit done;
    r = '0;
    if (it.cmd == kmdr_pkg::CMD_MAP) begin
      if (it.idx < KEYS) key_code[it.idx] = it.code;
    end else if (it.row < ROWS) begin
      lim = (threshold == kmdr_pkg::THR_TOP) ? kmdr_pkg::THR_MAX : threshold;
      for (int c = 0; c < COLS; c++) begin
        k = it.row * COLS + c;
        code = key_code[k];
        done = 1'b0;
        if (it.bits[c]) begin
          if (key_count[k] < lim) begin
            key_count[k]++;
          end else if (key_count[k] == lim) begin
            r.changed = 1'b1;
            key_count[k]++;
            for (int s = 0; s < SLOTS; s++) begin
              if (!done && slot_code[s] == '0) begin
                slot_code[s] = code;
                done = 1'b1;
              end
            end
          end
        end else if (key_count[k] > lim) begin
          r.changed = 1'b1;
          key_count[k] = '0;
          for (int s = 0; s < SLOTS; s++) begin
            if (!done && slot_code[s] == code) begin
              slot_code[s] = '0;
              done = 1'b1;
            end
          end
        end
      end
    end
    for (int s = 0; s < SLOTS && s < kmdr_pkg::SHOWN_SLOTS; s++) begin
      r.slots[8*s +: 8] = slot_code[s];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    report_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (report_queue.size() == 0) begin
        $error("output transfer with no result expected");
        errors++;
      end else begin
        exp_r = report_queue.pop_front();
        if (changed !== exp_r.changed) begin
          $error("changed: expected %0d, got %0d", exp_r.changed, changed);
          errors++;
        end
        if (report_slots !== exp_r.slots) begin
          $error("report_slots: expected %h, got %h", exp_r.slots, report_slots);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_item(input scan_item_t it, input logic typed, input report_t typed_r);
    report_t pred;
    if (sent_count < 230) begin
      send_idle = 25;
      recv_idle = 86;
    end else if (sent_count < 460) begin
      send_idle = 86;
      recv_idle = 25;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= it.cmd;
    row_index <= it.row;
    column_bits <= it.bits;
    map_index <= it.idx;
    map_code <= it.code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_report(it);
    report_queue.push_back(typed ? typed_r : pred);
    sent_count++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (report_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [kmdr_pkg::CNT_W-1:0] value);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= kmdr_pkg::ADDR_THRESHOLD;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    threshold = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[kmdr_pkg::CNT_W-1:0] !== value) begin
      $error("debounce_threshold: expected %0d, got %0d", value, rd[kmdr_pkg::CNT_W-1:0]);
      errors++;
    end
  endtask

  task automatic run_random(input int n, input bit hold_row0);
    scan_item_t it;
    int r;
    if (hold_row0) held[0] = 5'($urandom_range(31, 1));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      it.idx = 5'($urandom_range(31));
      it.code = 8'($urandom_range(255));
      it.row = 3'($urandom_range(7));
      it.bits = 5'($urandom_range(31));
      if (r < 8) begin
        it.cmd = kmdr_pkg::CMD_MAP;
        if ($urandom_range(7) == 0) it.code = '0;
      end else if (r < 14) begin
        it.cmd = kmdr_pkg::CMD_SCAN;
      end else begin
        it.cmd = kmdr_pkg::CMD_SCAN;
        if (hold_row0 && $urandom_range(99) < 95) it.row = '0;
        else it.row = 3'($urandom_range(ROWS - 1));
        if (!(hold_row0 && it.row == 0)) begin
          for (int c = 0; c < COLS; c++) begin
            if ($urandom_range(7) == 0) held[it.row][c] = ~held[it.row][c];
          end
        end
        it.bits = held[it.row];
      end
      send_item(it, 1'b0, '0);
    end
    drain_reports();
  endtask

  initial begin
    threshold = kmdr_pkg::THR_RESET;
    for (int k = 0; k < KEYS; k++) begin
      key_count[k] = '0;
      key_code[k] = 8'(int'(kmdr_pkg::FIRST_CODE) + k);
    end
    for (int s = 0; s < SLOTS; s++) slot_code[s] = '0;
    for (int rw = 0; rw < ROWS; rw++) held[rw] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(directed); i++) begin
      send_item(directed[i].item, directed[i].typed, directed[i].result);
    end
    drain_reports();

    run_random(70, 1'b0);
    write_threshold(8'd0);
    run_random(70, 1'b0);
    write_threshold(8'd1);
    run_random(60, 1'b0);
    write_threshold(8'($urandom_range(20, 2)));
    run_random(60, 1'b0);
    write_threshold(kmdr_pkg::THR_MAX);
    run_random(220, 1'b1);
    write_threshold(kmdr_pkg::THR_TOP);
    run_random(50, 1'b0);
    write_threshold(8'd3);
    run_random(50, 1'b0);

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/kmdr_pkg.sv
src/kmdr_ram.sv
src/kmdr_slots.sv
src/kmdr_ctrl.sv
src/key_matrix_debounce_report_unit.sv
tb/testbench.sv
